### rtl/text_console_cursor_engine_defines.svh
// Assertion macros for the text console cursor engine.
// Used by tcce_back, which checks its own logic; no other dependencies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/tcce_pkg.sv
// Shared types, codes and color conversion for the text console cursor engine.
// No dependencies.
package tcce_pkg;

    // input operations
    localparam logic OP_PRINT = 1'b0;
    localparam logic OP_SET   = 1'b1;

    // output commands
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    // classified request kinds
    localparam logic [2:0] K_SET  = 3'd0;
    localparam logic [2:0] K_CR   = 3'd1;
    localparam logic [2:0] K_LF   = 3'd2;
    localparam logic [2:0] K_TAB  = 3'd3;
    localparam logic [2:0] K_CHAR = 3'd4;

    // special bytes
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] FILL_GLYPH = 8'd219;

    localparam int CELL_HEIGHT = 8;

    // configuration register indexes
    localparam logic [2:0] REG_TEXT_COLOR  = 3'd0;
    localparam logic [2:0] REG_BACK_COLOR  = 3'd1;
    localparam logic [2:0] REG_BACK_ENABLE = 3'd2;
    localparam logic [2:0] REG_CLEAR_ROW   = 3'd3;
    localparam logic [2:0] REG_PIXEL_MODE  = 3'd4;
    localparam logic [2:0] REG_COLUMNS     = 3'd5;
    localparam logic [2:0] REG_ROWS        = 3'd6;

    localparam logic [6:0] COL_MIN = 7'd8;
    localparam logic [6:0] COL_MAX = 7'd68;
    localparam logic [5:0] ROW_MIN = 6'd1;
    localparam logic [5:0] ROW_MAX = 6'd34;

    localparam logic [1:0] PM_565  = 2'd0;
    localparam logic [1:0] PM_5551 = 2'd1;
    localparam logic [1:0] PM_4444 = 2'd2;
    localparam logic [1:0] PM_8888 = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_byte;
        logic [6:0] new_col;
        logic [5:0] new_row;
    } t_in_item;

    typedef struct packed {
        logic        command;
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [7:0]  glyph;
        logic [31:0] fore_pixel;
        logic [31:0] back_pixel;
        logic        write_back;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] glyph;
        logic [6:0] col;
        logic [5:0] row;
    } t_cmd;

    typedef struct packed {
        logic [31:0] text_color;
        logic [31:0] back_color;
        logic        back_en;
        logic        clr_en;
        logic [1:0]  pixel_mode;
        logic [6:0]  col_limit;
        logic [5:0]  row_limit;
    } t_cfg;

    function automatic logic [31:0] to_format(input logic [31:0] c, input logic [1:0] mode);
        logic [31:0] res;
        res = c;
        case (mode)
            PM_565:  res = {16'h0, c[23:19], c[15:10], c[7:3]};
            PM_5551: res = {16'h0, (c[31:24] != 8'h0), c[23:19], c[15:11], c[7:3]};
            PM_4444: res = {16'h0, c[31:28], c[23:20], c[15:12], c[7:4]};
            default: res = c;
        endcase
        return res;
    endfunction

endpackage

### rtl/tcce_front.sv
// Front end: accepts input requests and sorts them into command kinds.
// Depends on tcce_pkg.
module tcce_front (
    input  logic              i_valid,
    output logic              o_stall,
    input  tcce_pkg::t_in_item i_item,
    output logic              o_push,
    output tcce_pkg::t_cmd    o_cmd,
    input  logic              i_full
);

    always_comb begin
        o_cmd.glyph = i_item.char_byte;
        o_cmd.col   = i_item.new_col;
        o_cmd.row   = i_item.new_row;
        if (i_item.operation == tcce_pkg::OP_SET) begin
            o_cmd.kind = tcce_pkg::K_SET;
        end else begin
            case (i_item.char_byte)
                tcce_pkg::CH_CR:  o_cmd.kind = tcce_pkg::K_CR;
                tcce_pkg::CH_LF:  o_cmd.kind = tcce_pkg::K_LF;
                tcce_pkg::CH_TAB: begin
                    o_cmd.kind  = tcce_pkg::K_TAB;
                    o_cmd.glyph = tcce_pkg::CH_SPACE;
                end
                default:          o_cmd.kind = tcce_pkg::K_CHAR;
            endcase
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

### rtl/tcce_queue.sv
// Two-entry queue of classified commands between front and back end.
// Depends on tcce_pkg.
module tcce_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcce_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tcce_pkg::t_cmd o_cmd
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    tcce_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [AW:0]    r_count;

    logic do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/tcce_back.sv
// Back end: owns the cursor and sequences draw and row-fill results.
// Depends on tcce_pkg and text_console_cursor_engine_defines.svh.
`include "text_console_cursor_engine_defines.svh"
module tcce_back #(
    parameter int CELL_WIDTH = 7,
    parameter int TAB_WIDTH  = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcce_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  tcce_pkg::t_cmd     i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tcce_pkg::t_out_item o_out
);

    localparam int CW = $clog2(TAB_WIDTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DRAW  = 2'd1;
    localparam logic [1:0] S_CLEAR = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [6:0]  r_col, n_col;
    logic [5:0]  r_row, n_row;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]  r_glyph, n_glyph;
    logic        r_out_valid, n_out_valid;
    tcce_pkg::t_out_item r_out, n_out;

    logic        slot_free, wrap, clr, emit;
    logic [5:0]  row_next, fill_row;
    logic [15:0] x_prod, y_prod;
    logic        e_cmd, e_last;
    logic [7:0]  e_glyph;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign clr       = i_cfg.clr_en && i_cfg.back_en;
    assign wrap      = ({1'b0, r_col} + 8'd1) >= {1'b0, i_cfg.col_limit};
    assign row_next  = (({1'b0, r_row} + 7'd1) >= {1'b0, i_cfg.row_limit}) ? '0 : r_row + 6'd1;
    assign x_prod    = 16'(r_col) * 16'(CELL_WIDTH);

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_glyph     = r_glyph;
        o_q_pop     = 1'b0;
        emit        = 1'b0;
        e_cmd       = tcce_pkg::CMD_DRAW;
        e_last      = 1'b0;
        e_glyph     = r_glyph;
        fill_row    = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.kind)
                        tcce_pkg::K_SET: begin
                            o_q_pop = 1'b1;
                            if (i_q_cmd.col < i_cfg.col_limit) n_col = i_q_cmd.col;
                            if (i_q_cmd.row < i_cfg.row_limit) n_row = i_q_cmd.row;
                        end
                        tcce_pkg::K_CR: begin
                            o_q_pop = 1'b1;
                            n_col   = '0;
                        end
                        tcce_pkg::K_LF: begin
                            // wait for the output slot only when a fill goes out
                            if (!clr || slot_free) begin
                                o_q_pop  = 1'b1;
                                n_col    = '0;
                                n_row    = row_next;
                                fill_row = row_next;
                                emit     = clr;
                                e_cmd    = tcce_pkg::CMD_FILL;
                                e_last   = 1'b1;
                            end
                        end
                        tcce_pkg::K_TAB: begin
                            o_q_pop = 1'b1;
                            n_glyph = i_q_cmd.glyph;
                            n_cnt   = CW'(TAB_WIDTH);
                            n_state = S_DRAW;
                        end
                        default: begin
                            o_q_pop = 1'b1;
                            n_glyph = i_q_cmd.glyph;
                            n_cnt   = CW'(1);
                            n_state = S_DRAW;
                        end
                    endcase
                end
            end
            S_DRAW: begin
                if (slot_free) begin
                    emit   = 1'b1;
                    e_last = !(wrap && clr) && (r_cnt == CW'(1));
                    if (wrap) begin
                        n_col = '0;
                        n_row = row_next;
                    end else begin
                        n_col = r_col + 7'd1;
                    end
                    if (wrap && clr) begin
                        n_state = S_CLEAR;
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) n_state = S_IDLE;
                    end
                end
            end
            S_CLEAR: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_cmd   = tcce_pkg::CMD_FILL;
                    e_last  = (r_cnt == CW'(1));
                    n_cnt   = r_cnt - CW'(1);
                    n_state = (r_cnt == CW'(1)) ? S_IDLE : S_DRAW;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign y_prod = 16'(fill_row) * 16'(tcce_pkg::CELL_HEIGHT);

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.command    = e_cmd;
            n_out.pixel_x    = (e_cmd == tcce_pkg::CMD_FILL) ? 9'd0 : x_prod[8:0];
            n_out.pixel_y    = y_prod[8:0];
            n_out.glyph      = (e_cmd == tcce_pkg::CMD_FILL) ? tcce_pkg::FILL_GLYPH : e_glyph;
            n_out.fore_pixel = tcce_pkg::to_format(
                (e_cmd == tcce_pkg::CMD_FILL) ? i_cfg.back_color : i_cfg.text_color,
                i_cfg.pixel_mode);
            n_out.back_pixel = tcce_pkg::to_format(i_cfg.back_color, i_cfg.pixel_mode);
            n_out.write_back = i_cfg.back_en;
            n_out.last       = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `TCCE_ASSERT(a_clear_needs_enable, i_clk, i_rst_n, (r_state == S_CLEAR) |-> clr, "row fill pending while clearing is disabled")
    `TCCE_ASSERT(a_busy_has_count, i_clk, i_rst_n, (r_state != S_IDLE) |-> (r_cnt != '0), "sequencer busy with no steps left")
    `TCCE_ASSERT(a_advance_no_wrap, i_clk, i_rst_n, (r_state == S_DRAW && slot_free && !wrap) |=> (r_col == $past(r_col) + 7'd1), "cursor column did not advance after a draw")
    `TCCE_ASSERT(a_fill_at_left, i_clk, i_rst_n, (r_out_valid && r_out.command == tcce_pkg::CMD_FILL) |-> (r_out.pixel_x == 9'd0 && r_out.glyph == tcce_pkg::FILL_GLYPH), "row fill with bad position or glyph")

endmodule

### rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: config registers, front, queue, back.
// Depends on tcce_pkg, tcce_front, tcce_queue and tcce_back.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in  (t_in_item)
//   out      output     o_out_valid / i_out_stall o_out (t_out_item)
//   cfg      input      i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// A printable byte takes two back-end steps (fetch, draw); a tab takes one fetch
// step plus one draw per space, and each wrap with row clearing adds one fill step.
// Set-cursor, carriage return and line feed take only the fetch step.
// The two-entry queue takes requests while the back end works and stalls the input
// when full; a stalled result holds in the output register, the next loads as it goes.
// Reset is synchronous: cursor to the top left, registers to their defaults.
module text_console_cursor_engine #(
    parameter int CELL_WIDTH = 7,
    parameter int TAB_WIDTH  = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tcce_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tcce_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_wdata
);

    logic [31:0] r_text_color, r_back_color;
    logic        r_back_en, r_clr_en;
    logic [1:0]  r_pixel_mode;
    logic [6:0]  r_columns;
    logic [5:0]  r_rows;

    tcce_pkg::t_cfg cfg;
    tcce_pkg::t_cmd front_cmd, q_cmd;
    logic           push, q_full, q_valid, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= 32'hFFFF_FFFF;
            r_back_color <= 32'h0;
            r_back_en    <= 1'b1;
            r_clr_en     <= 1'b1;
            r_pixel_mode <= tcce_pkg::PM_8888;
            r_columns    <= 7'd68;
            r_rows       <= 6'd34;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcce_pkg::REG_TEXT_COLOR:  r_text_color <= i_cfg_wdata;
                tcce_pkg::REG_BACK_COLOR:  r_back_color <= i_cfg_wdata;
                tcce_pkg::REG_BACK_ENABLE: r_back_en    <= i_cfg_wdata[0];
                tcce_pkg::REG_CLEAR_ROW:   r_clr_en     <= i_cfg_wdata[0];
                tcce_pkg::REG_PIXEL_MODE:  r_pixel_mode <= i_cfg_wdata[1:0];
                tcce_pkg::REG_COLUMNS:     r_columns    <= i_cfg_wdata[6:0];
                tcce_pkg::REG_ROWS:        r_rows       <= i_cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // clamp the text area to the supported range
    always_comb begin
        cfg.text_color = r_text_color;
        cfg.back_color = r_back_color;
        cfg.back_en    = r_back_en;
        cfg.clr_en     = r_clr_en;
        cfg.pixel_mode = r_pixel_mode;
        cfg.col_limit  = (r_columns < tcce_pkg::COL_MIN) ? tcce_pkg::COL_MIN :
                         (r_columns > tcce_pkg::COL_MAX) ? tcce_pkg::COL_MAX : r_columns;
        cfg.row_limit  = (r_rows < tcce_pkg::ROW_MIN) ? tcce_pkg::ROW_MIN :
                         (r_rows > tcce_pkg::ROW_MAX) ? tcce_pkg::ROW_MAX : r_rows;
    end

    tcce_front u_front (
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (q_full)
    );

    tcce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    tcce_back #(
        .CELL_WIDTH (CELL_WIDTH),
        .TAB_WIDTH  (TAB_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

### test/tb.sv
// Testbench for text_console_cursor_engine: directed and random print and set-cursor requests,
// checked against a cursor and color predictor kept in this file.
// Depends on tcce_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
    import tcce_pkg::*;

    localparam int SETTLE_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    logic        in_stall;
    logic        out_valid;
    t_out_item   out_data;

    // predictor state
    logic [31:0] cfg_text;
    logic [31:0] cfg_back;
    logic        cfg_back_en;
    logic        cfg_clr_en;
    logic [1:0]  cfg_mode;
    logic [6:0]  cfg_cols;
    logic [5:0]  cfg_rows;
    int          cur_col;
    int          cur_row;

    t_out_item   pending_cmds[$];
    t_out_item   step_cmds[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_len_req = 0;
    int          hold_left = 0;

    text_console_cursor_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [31:0] pack_color(input logic [31:0] c);
        logic [31:0] r;
        case (cfg_mode)
            PM_565:  r = {16'h0, c[23:19], c[15:10], c[7:3]};
            PM_5551: r = {16'h0, |c[31:24], c[23:19], c[15:11], c[7:3]};
            PM_4444: r = {16'h0, c[31:28], c[23:20], c[15:12], c[7:4]};
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic int col_bound();
        if (cfg_cols < 7'd8) return 8;
        if (cfg_cols > 7'd68) return 68;
        return int'(cfg_cols);
    endfunction

    function automatic int row_bound();
        if (cfg_rows < 6'd1) return 1;
        if (cfg_rows > 6'd34) return 34;
        return int'(cfg_rows);
    endfunction

    function automatic void push_cmd(input logic cmd, input logic [31:0] x,
                                     input logic [31:0] y, input logic [7:0] g,
                                     input logic [31:0] fore);
        t_out_item r;
        r.command    = cmd;
        r.pixel_x    = x[8:0];
        r.pixel_y    = y[8:0];
        r.glyph      = g;
        r.fore_pixel = pack_color(fore);
        r.back_pixel = pack_color(cfg_back);
        r.write_back = cfg_back_en;
        r.last       = 1'b0;
        step_cmds.push_back(r);
    endfunction

    function automatic void enter_next_row();
        cur_row = (cur_row + 1 >= row_bound()) ? 0 : cur_row + 1;
        if (cfg_clr_en && cfg_back_en)
            push_cmd(CMD_FILL, 0, cur_row * CELL_HEIGHT, FILL_GLYPH, cfg_back);
    endfunction

    function automatic void draw_and_advance(input logic [7:0] g);
        push_cmd(CMD_DRAW, cur_col * 7, cur_row * CELL_HEIGHT, g, cfg_text);
        if (cur_col + 1 >= col_bound()) begin
            cur_col = 0;
            enter_next_row();
        end else begin
            cur_col++;
        end
    endfunction

    function automatic void render_request(input t_in_item it);
        step_cmds.delete();
        if (it.operation == OP_SET) begin
            if (int'(it.new_col) < col_bound()) cur_col = int'(it.new_col);
            if (int'(it.new_row) < row_bound()) cur_row = int'(it.new_row);
        end else if (it.char_byte == CH_CR) begin
            cur_col = 0;
        end else if (it.char_byte == CH_LF) begin
            cur_col = 0;
            enter_next_row();
        end else if (it.char_byte == CH_TAB) begin
            for (int i = 0; i < 5; i++)
                draw_and_advance(CH_SPACE);
        end else begin
            draw_and_advance(it.char_byte);
        end
        if (step_cmds.size() > 0)
            step_cmds[step_cmds.size() - 1].last = 1'b1;
        foreach (step_cmds[i])
            pending_cmds.push_back(step_cmds[i]);
    endfunction

    // ---------------- result checker and receiver stall ----------------

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_cmds.size() == 0) begin
                $error("unexpected result: command %0d glyph %h", out_data.command,
                       out_data.glyph);
                errors++;
            end else begin
                exp_r = pending_cmds.pop_front();
                check_field("command", 32'(exp_r.command), 32'(out_data.command));
                check_field("pixel_x", 32'(exp_r.pixel_x), 32'(out_data.pixel_x));
                check_field("pixel_y", 32'(exp_r.pixel_y), 32'(out_data.pixel_y));
                check_field("glyph", 32'(exp_r.glyph), 32'(out_data.glyph));
                check_field("fore_pixel", exp_r.fore_pixel, out_data.fore_pixel);
                check_field("back_pixel", exp_r.back_pixel, out_data.back_pixel);
                check_field("write_back", 32'(exp_r.write_back), 32'(out_data.write_back));
                check_field("last", 32'(exp_r.last), 32'(out_data.last));
            end
        end
        if (hold_len_req != 0) begin
            hold_left = hold_len_req;
            hold_len_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ---------------- drivers ----------------

    // Call right after a rising edge; valid stays high after acceptance.
    task automatic send_request(input t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
        render_request(it);
    endtask

    task automatic send_print(input logic [7:0] ch);
        t_in_item it;
        it = '0;
        it.operation = OP_PRINT;
        it.char_byte = ch;
        it.new_col   = 7'($urandom);
        it.new_row   = 6'($urandom);
        send_request(it);
    endtask

    task automatic send_set(input logic [6:0] col, input logic [5:0] row);
        t_in_item it;
        it.operation = OP_SET;
        it.char_byte = 8'($urandom);
        it.new_col   = col;
        it.new_row   = row;
        send_request(it);
    endtask

    // Drop valid, wait for every pending result, then let the block settle.
    task automatic drain_console();
        in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TEXT_COLOR:  cfg_text    = data;
            REG_BACK_COLOR:  cfg_back    = data;
            REG_BACK_ENABLE: cfg_back_en = data[0];
            REG_CLEAR_ROW:   cfg_clr_en  = data[0];
            REG_PIXEL_MODE:  cfg_mode    = data[1:0];
            REG_COLUMNS:     cfg_cols    = data[6:0];
            REG_ROWS:        cfg_rows    = data[5:0];
            default: ;
        endcase
    endtask

    // ---------------- tests ----------------

    task automatic test_print_basics();
        send_print(8'h00);
        send_print(8'hFF);
        send_print(8'd65);
        send_print(CH_CR);
        send_print(CH_LF);
        send_print(CH_TAB);
        send_set(7'd3, 6'd2);
        drain_console();
    endtask

    task automatic test_wrap_edges();
        send_set(7'd67, 6'd33);
        send_print(8'd120);          // wraps column and row, clears row 0
        send_set(7'd65, 6'd5);
        send_print(CH_TAB);          // wraps in the middle of the tab
        send_set(7'd127, 6'd63);     // both out of range, cursor kept
        send_set(7'd0, 6'd63);
        send_print(CH_LF);
        drain_console();
    endtask

    task automatic test_limit_clamp();
        send_set(7'd60, 6'd30);
        drain_console();
        // limits below range clamp to 8 columns, 1 row; cursor now past both
        write_reg(REG_COLUMNS, 32'h0);
        write_reg(REG_ROWS, 32'h0);
        send_print(8'd97);
        drain_console();
        write_reg(REG_COLUMNS, 32'h7F);
        write_reg(REG_ROWS, 32'h3F);
        send_set(7'd67, 6'd33);
        send_print(8'd98);
        drain_console();
        write_reg(REG_COLUMNS, 32'd68);
        write_reg(REG_ROWS, 32'd34);
    endtask

    task automatic test_pixel_modes();
        write_reg(REG_BACK_COLOR, 32'h12345678);
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_PIXEL_MODE, 32'(m));
            write_reg(REG_TEXT_COLOR, $urandom | 32'h0100_0000);
            send_print(8'd90);
            drain_console();
        end
        // alpha zero in 5551
        write_reg(REG_PIXEL_MODE, 32'(PM_5551));
        write_reg(REG_TEXT_COLOR, 32'h00FF_FFFF);
        send_print(CH_LF);
        send_print(8'd90);
        drain_console();
        write_reg(REG_PIXEL_MODE, 32'(PM_8888));
    endtask

    task automatic test_clear_gating();
        write_reg(REG_BACK_ENABLE, 32'h0);
        send_print(CH_LF);           // no result
        send_set(7'd67, 6'd4);
        send_print(8'd66);           // wrap without fill
        drain_console();
        write_reg(REG_BACK_ENABLE, 32'h1);
        write_reg(REG_CLEAR_ROW, 32'h0);
        send_print(CH_LF);
        send_print(8'd67);
        drain_console();
        write_reg(REG_CLEAR_ROW, 32'h1);
    endtask

    function automatic t_in_item random_request();
        t_in_item it;
        int pick;
        it.operation = OP_PRINT;
        it.char_byte = 8'($urandom);
        it.new_col   = 7'($urandom);
        it.new_row   = 6'($urandom);
        pick = $urandom_range(99);
        if (pick < 15) begin
            it.operation = OP_SET;
            if ($urandom_range(1)) begin
                it.new_col = 7'($urandom_range(col_bound() - 1));
                it.new_row = 6'($urandom_range(row_bound() - 1));
            end
        end else if (pick < 27) begin
            it.char_byte = CH_LF;
        end else if (pick < 35) begin
            it.char_byte = CH_CR;
        end else if (pick < 47) begin
            it.char_byte = CH_TAB;
        end
        return it;
    endfunction

    task automatic test_random_phase(input int count, input int send_pct, input int recv_pct,
                                     input logic [6:0] cols, input logic [5:0] rows);
        logic [31:0] junk;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        junk = $urandom;
        write_reg(REG_TEXT_COLOR, $urandom);
        write_reg(REG_BACK_COLOR, $urandom);
        write_reg(REG_BACK_ENABLE, {junk[31:1], ($urandom_range(3) != 0)});
        write_reg(REG_CLEAR_ROW, {junk[31:1], ($urandom_range(3) != 0)});
        write_reg(REG_PIXEL_MODE, {junk[31:2], 2'($urandom)});
        write_reg(REG_COLUMNS, {junk[31:7], cols});
        write_reg(REG_ROWS, {junk[31:6], rows});
        for (int i = 0; i < count; i++)
            send_request(random_request());
        drain_console();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len_req = 300;
        // keep offering while the receiver holds off; the block fills and stalls
        for (int i = 0; i < 24; i++)
            send_print(($urandom_range(3) == 0) ? CH_TAB : 8'($urandom_range(32, 126)));
        drain_console();
    endtask

    initial begin
        cfg_text    = 32'hFFFF_FFFF;
        cfg_back    = 32'h0;
        cfg_back_en = 1'b1;
        cfg_clr_en  = 1'b1;
        cfg_mode    = PM_8888;
        cfg_cols    = 7'd68;
        cfg_rows    = 6'd34;
        cur_col     = 0;
        cur_row     = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        send_idle_pct = 15;
        recv_idle_pct = 81;
        test_print_basics();
        test_wrap_edges();
        test_limit_clamp();
        test_pixel_modes();
        test_clear_gating();

        test_random_phase(150, 15, 81, 7'd8, 6'd1);
        test_random_phase(150, 81, 15, 7'd68, 6'd34);
        test_random_phase(75, 0, 0, 7'($urandom), 6'($urandom));
        test_random_phase(75, 0, 0, 7'($urandom_range(8, 20)), 6'($urandom_range(2, 5)));
        test_backpressure();

        drain_console();
        if (pending_cmds.size() != 0) begin
            $error("%0d expected results never arrived", pending_cmds.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
